// ===== sv/tefm_pkg.sv =====
// Package for the timed effect force mixer: widths, opcodes, slot record type.
// No dependencies.
package tefm_pkg;
	localparam int SLOTS_DEF = 5;
	localparam logic [7:0] FORCE_FULL = 8'hFE;
	localparam logic [31:0] INF_TIME = 32'hFFFF_FFFF;
	localparam logic [31:0] LATE_RUN_MS = 32'd100;

	typedef enum logic [1:0] {
		FN_TICK  = 2'd0,
		FN_START = 2'd1,
		FN_STOP  = 2'd2,
		FN_ALL   = 2'd3
	} func_t;

	localparam logic CFG_CAP_EN = 1'b0;
	localparam logic CFG_CAP_MS = 1'b1;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] start;
		logic [31:0] stop;
		logic [7:0]  fs;
		logic [7:0]  fb;
		logic        active;
		logic        started;
	} slot_t;

	// token walking along the row of cells
	typedef struct packed {
		logic        valid;
		func_t       fn;
		logic [31:0] now;
		logic [31:0] id;
		logic [7:0]  mix_s;
		logic [7:0]  mix_b;
	} tok_t;

	// start payload, resolved before the walk
	typedef struct packed {
		logic [7:0]  fs;
		logic [7:0]  fb;
		logic [31:0] start;
		logic [31:0] stop;
	} wr_t;
endpackage

// ===== sv/tefm_cell.sv =====
// One effect slot cell: holds a slot and processes the token passing through.
// Depends on tefm_pkg.
module tefm_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  tefm_pkg::tok_t tok_in,
	input  tefm_pkg::wr_t  wr,
	input  logic           sel_here,   // start target chosen for this cell
	input  logic           cap_en,
	input  logic [15:0]    cap_ms,
	output tefm_pkg::tok_t tok_out,
	output tefm_pkg::slot_t slot
);
	import tefm_pkg::*;

	slot_t slot_q, slot_d;
	tok_t  tok_q, tok_d;

	always_comb begin
		logic mix;
		mix = 1'b0;
		slot_d = slot_q;
		tok_d = tok_in;
		if (tok_in.valid) begin
			case (tok_in.fn)
				FN_TICK: begin
					if (slot_q.active) begin
						if (slot_q.started) begin
							if (slot_q.stop != INF_TIME && slot_q.stop <= tok_in.now)
								slot_d.active = 1'b0;
							else
								mix = 1'b1;
						end else if (slot_q.start <= tok_in.now) begin
							slot_d.started = 1'b1;
							if (slot_q.stop != INF_TIME)
								slot_d.stop = tok_in.now + ((slot_q.start <= slot_q.stop) ?
									slot_q.stop - slot_q.start : slot_q.start + LATE_RUN_MS);
							else if (cap_en)
								slot_d.stop = tok_in.now + {16'd0, cap_ms};
							mix = 1'b1;
						end
					end
					if (mix && slot_q.fs > tok_in.mix_s) tok_d.mix_s = slot_q.fs;
					if (mix && slot_q.fb > tok_in.mix_b) tok_d.mix_b = slot_q.fb;
				end
				FN_START: begin
					if (sel_here) begin
						slot_d.id = tok_in.id;
						slot_d.fs = wr.fs;
						slot_d.fb = wr.fb;
						slot_d.start = wr.start;
						slot_d.stop = wr.stop;
						slot_d.active = 1'b1;
						slot_d.started = 1'b0;
					end
				end
				FN_STOP: begin
					if (slot_q.id == tok_in.id) slot_d.stop = 32'd0;
				end
				default: begin
					slot_d = '{id: INF_TIME, default: '0};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '{id: INF_TIME, default: '0};
			tok_q <= '0;
		end else begin
			slot_q <= slot_d;
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;
	assign slot = slot_q;
endmodule

// ===== sv/timed_effect_force_mixer.sv =====
// Timed effect force mixer: front end, row of slot cells, output compare.
// An accepted item is registered at the front end, passes through the register of each
// cell in turn, and the output compare registers the strobe. One item at a time: busy
// holds off the next item until the token has walked the cell row and the countdown ends.
// Results carry no back-pressure. Reset is asynchronous, active low, and clears
// all slots and sent values; config resets to cap enabled, 1000 ms.
// Depends on tefm_pkg, tefm_cell.
module timed_effect_force_mixer #(
	parameter int SLOTS = tefm_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [31:0] now_ms,
	input  logic [31:0] effect_id,
	input  logic        has_magnitude,
	input  logic signed [14:0] magnitude_raw,
	input  logic [1:0]  axis_count,
	input  logic signed [31:0] direction_first,
	input  logic signed [31:0] direction_second,
	input  logic [31:0] start_delay_us,
	input  logic [31:0] duration_us,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        strobe,
	output logic [7:0]  small_motor_force,
	output logic [7:0]  big_motor_force
);
	import tefm_pkg::*;
	localparam int CW = $clog2(SLOTS + 3);
	localparam logic [60:0] RECIP_1000 = 61'd274877907;  // ceil(2^38/1000)

	logic        cap_en_q;
	logic [15:0] cap_ms_q;
	logic [7:0]  sa_small_q, sa_big_q, sent_s_q, sent_b_q;
	logic [CW-1:0] cnt_q;
	logic        busy_q;
	tok_t        tok_s1;
	wr_t         wr_s1;
	logic [SLOTS-1:0] sel_s1;

	tok_t  chain [SLOTS+1];
	slot_t slots [SLOTS];

	// magnitude: (127*(m+10000)+5000)/10000 via reciprocal
	logic signed [14:0] mcl;
	logic [14:0] mv;
	logic [21:0] mnum;
	logic [7:0]  mag, mq, fs_n, fb_n, sa_s_n, sa_b_n;
	logic [47:0] mprod;
	always_comb begin
		mcl = magnitude_raw;
		if (magnitude_raw > 15'sd10000) mcl = 15'sd10000;
		if (magnitude_raw < -15'sd10000) mcl = -15'sd10000;
		mv = 15'(mcl + 15'sd10000);
		mnum = 22'(mv * 7'd127) + 22'd5000;
		mprod = {26'd0, mnum} * 48'd109951163;  // ceil(2^40/10000), exact here
		mq = mprod[47:40];
		mag = has_magnitude ? mq : FORCE_FULL;
		sa_s_n = sa_small_q;
		sa_b_n = sa_big_q;
		fs_n = FORCE_FULL;
		fb_n = FORCE_FULL;
		if (axis_count == 2'd1) begin
			if (direction_first == -32'sd1) sa_s_n = mag;
			else if (direction_first == 32'sd1) sa_b_n = mag;
			fs_n = sa_s_n;
			fb_n = sa_b_n;
		end else if (axis_count >= 2'd2) begin
			fs_n = (direction_first > 0) ? mag : 8'd0;
			fb_n = (direction_second > 0) ? mag : 8'd0;
		end
	end

	// slot pick for a start (id match, else first inactive, else last)
	logic [SLOTS-1:0] sel_n;
	logic [31:0] st_n, sp_n;
	logic [60:0] dly_prod, dur_prod;
	always_comb begin
		logic done;
		done = 1'b0;
		sel_n = '0;
		for (int k = 0; k < SLOTS; k++)
			if (!done && slots[k].id == effect_id) begin
				sel_n[k] = 1'b1; done = 1'b1;
			end
		for (int k = 0; k < SLOTS; k++)
			if (!done && (!slots[k].active || k == SLOTS - 1)) begin
				sel_n[k] = 1'b1; done = 1'b1;
			end
		// us to ms by reciprocal multiply, exact over the full 32-bit range
		dly_prod = {29'd0, start_delay_us} * RECIP_1000;
		dur_prod = {29'd0, duration_us} * RECIP_1000;
		st_n = now_ms + {9'd0, dly_prod[60:38]};
		sp_n = (duration_us == INF_TIME) ? INF_TIME : st_n + {9'd0, dur_prod[60:38]};
	end

	logic acc;
	assign acc = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_en_q <= 1'b1;
			cap_ms_q <= 16'd1000;
			sa_small_q <= '0;
			sa_big_q <= '0;
			busy_q <= 1'b0;
			cnt_q <= '0;
			tok_s1 <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_CAP_EN) cap_en_q <= cfg_data[0];
				else cap_ms_q <= cfg_data;
			end
			if (acc) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(SLOTS + 1);
				tok_s1 <= '{valid: 1'b1, fn: func_t'(func), now: now_ms, id: effect_id,
					mix_s: 8'd0, mix_b: 8'd0};
				if (func_t'(func) == FN_START) begin
					sa_small_q <= sa_s_n;
					sa_big_q <= sa_b_n;
				end
			end else begin
				tok_s1.valid <= 1'b0;
				if (busy_q) begin
					if (cnt_q == '0) busy_q <= 1'b0;
					else cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			sel_s1 <= sel_n;
			wr_s1 <= '{fs: fs_n, fb: fb_n, start: st_n, stop: sp_n};
		end
	end

	assign chain[0] = tok_s1;
	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		tefm_cell u_cell (
			.clk(clk), .arst_n(arst_n), .tok_in(chain[g]), .wr(wr_s1),
			.sel_here(sel_s1[g]), .cap_en(cap_en_q), .cap_ms(cap_ms_q),
			.tok_out(chain[g+1]), .slot(slots[g])
		);
	end

	tok_t tl;
	assign tl = chain[SLOTS];
	logic emit;
	assign emit = tl.valid && (tl.fn == FN_ALL ||
		(tl.fn == FN_TICK && (tl.mix_s != sent_s_q || tl.mix_b != sent_b_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sent_s_q <= '0;
			sent_b_q <= '0;
			strobe <= 1'b0;
			small_motor_force <= '0;
			big_motor_force <= '0;
		end else begin
			strobe <= emit;
			if (emit) begin
				sent_s_q <= tl.mix_s;
				sent_b_q <= tl.mix_b;
				small_motor_force <= tl.mix_s;
				big_motor_force <= tl.mix_b;
			end
		end
	end

	assign busy = busy_q;
endmodule

// ===== sv/tefm_checker.sv =====
// Port-level checks for timed_effect_force_mixer, bound to the top level.
// Depends on tefm_pkg and the top-level ports.
module tefm_assertions (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] func,
	input logic       strobe,
	input logic [7:0] small_motor_force,
	input logic [7:0] big_motor_force
);
	import tefm_pkg::*;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("no busy after item");
	a_stopall_zero: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FN_ALL |=> ##6 strobe && small_motor_force == 8'd0
		&& big_motor_force == 8'd0) else $error("stop-all result missing");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> small_motor_force <= 8'd254 && big_motor_force <= 8'd254)
		else $error("force out of range");
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |=> !strobe) else $error("double result");
endmodule

bind timed_effect_force_mixer tefm_assertions u_tefm_assertions (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
	.strobe(strobe), .small_motor_force(small_motor_force),
	.big_motor_force(big_motor_force)
);
